>>> hw/rtl/ehbi_pkg.sv
// shared constants and command types for the elf hash bucket index block
`timescale 1ns / 1ps
package ehbi_pkg;

   localparam int HASH_W    = 32;
   localparam int BYTE_W    = 8;
   localparam int CSR_IDX_W = 8;
   localparam int DIV_STEPS = HASH_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam logic [CSR_IDX_W-1:0] CSR_IGNORE_CASE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_SIZE  = CSR_IDX_W'(1);

   // command group from the controller to the datapath
   typedef struct packed {
      logic hash_en;    // a key byte beat is accepted
      logic div_start;  // last byte: load the divider, clear the running hash
      logic div_step;   // one restoring divider step
      logic load_out;   // copy the remainder into the result register
   } ctrl_cmd_type;

endpackage

>>> hw/rtl/ehbi_ctrl.sv
// controller state machine: byte acceptance, divider sequencing, result handshake
`timescale 1ns / 1ps
module ehbi_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_is_last,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ehbi_pkg::ctrl_cmd_type cmd
);
   import ehbi_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIVIDE,
      S_HOLD
   } state_type;

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   logic             out_free;

   // a last byte waits while the divider is in use
   assign req_stall = req_is_last && (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      cmd.hash_en   = accept;
      cmd.div_start = 1'b0;
      cmd.div_step  = 1'b0;
      cmd.load_out  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_is_last) begin
               cmd.div_start = 1'b1;
               count_in      = '0;
               state_in      = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + CNT_W'(1);
            if (count_ff == CNT_LAST) begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hw/rtl/ehbi_datapath.sv
// datapath: configuration registers, running hash, restoring divider, result register
`timescale 1ns / 1ps
module ehbi_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  ehbi_pkg::ctrl_cmd_type             cmd,
   input  logic [ehbi_pkg::BYTE_W-1:0]        req_key_byte,
   input  logic                               req_is_last,
   input  logic                               csr_we,
   input  logic [ehbi_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ehbi_pkg::HASH_W-1:0]        csr_data,
   output logic [ehbi_pkg::HASH_W-1:0]        rsp_bucket_index
);
   import ehbi_pkg::*;

   localparam logic [HASH_W-1:0] HASH_TOP_MASK   = 32'hF000_0000;
   localparam int                HASH_FOLD_SHIFT = 24;
   localparam int                HASH_STEP_SHIFT = 4;

   function automatic logic [BYTE_W-1:0] fold_case(input logic fold, input logic [BYTE_W-1:0] b);
      if (fold && b >= 8'h61 && b <= 8'h7A) begin
         return b - 8'h20;
      end
      return b;
   endfunction

   function automatic logic [HASH_W-1:0] hash_mix(input logic [HASH_W-1:0] h,
                                                  input logic [BYTE_W-1:0] b);
      logic [HASH_W-1:0] s;
      logic [HASH_W-1:0] g;
      s = (h << HASH_STEP_SHIFT) + HASH_W'(b);
      g = s & HASH_TOP_MASK;
      return s ^ (g >> HASH_FOLD_SHIFT) ^ g;
   endfunction

   logic              ignore_case_ff, ignore_case_in;
   logic [HASH_W-1:0] table_size_ff, table_size_in;
   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [HASH_W-1:0] rem_ff, rem_in;
   logic [HASH_W-1:0] dvd_ff, dvd_in;
   logic [HASH_W-1:0] dsr_ff, dsr_in;
   logic [HASH_W-1:0] out_ff, out_in;
   logic [HASH_W-1:0] mixed;
   logic [HASH_W:0]   trial;
   logic [HASH_W:0]   diff;

   assign mixed = hash_mix(hash_ff, fold_case(ignore_case_ff, req_key_byte));
   assign trial = {rem_ff, dvd_ff[HASH_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      ignore_case_in = ignore_case_ff;
      table_size_in  = table_size_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_IGNORE_CASE: ignore_case_in = csr_data[0];
            CSR_TABLE_SIZE:  table_size_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      hash_in = hash_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      out_in  = out_ff;
      if (cmd.hash_en) begin
         hash_in = req_is_last ? '0 : mixed;
      end
      if (cmd.div_start) begin
         rem_in = '0;
         dvd_in = mixed;
         dsr_in = table_size_ff;
      end else if (cmd.div_step) begin
         // with a zero divisor every step keeps the trial value, leaving the hash
         rem_in = diff[HASH_W] ? trial[HASH_W-1:0] : diff[HASH_W-1:0];
         dvd_in = dvd_ff << 1;
      end
      if (cmd.load_out) begin
         out_in = rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ignore_case_ff <= 1'b0;
         table_size_ff  <= HASH_W'(256);
         hash_ff        <= '0;
      end else begin
         ignore_case_ff <= ignore_case_in;
         table_size_ff  <= table_size_in;
         hash_ff        <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      out_ff <= out_in;
   end

   assign rsp_bucket_index = out_ff;

endmodule

>>> hw/rtl/elf_hash_bucket_index.sv
// top level of the elf hash bucket index block
`timescale 1ns / 1ps
// usage
// - req channel: one key byte per beat (req_key_byte) with req_is_last on the
//   final byte; a beat is taken when req_valid is high and req_stall is low
// - bytes that are not last fold into the running hash at one per cycle
// - the last byte starts a 32-step restoring remainder by table_size; the
//   result is then registered and shown on rsp_bucket_index
// - while the remainder runs, further bytes of the next key are still taken;
//   only its last byte is stalled, until the controller is back in idle
// - rsp channel: rsp_valid holds with a stable payload while rsp_stall is high;
//   a finished remainder waits in the divider until the result register frees
// - a table_size of zero returns the full hash
// - csr channel: csr_ready is always high; index 0 is ignore_case, index 1 is
//   table_size, other indexes are dropped; write only while the block is idle
// - reset (synchronous, active high) clears the running hash, sets
//   ignore_case to 0 and table_size to 256, and clears rsp_valid (not the result value)
module elf_hash_bucket_index (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ehbi_pkg::BYTE_W-1:0]    req_key_byte,
   input  logic                           req_is_last,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ehbi_pkg::HASH_W-1:0]    rsp_bucket_index,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ehbi_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ehbi_pkg::HASH_W-1:0]    csr_data
);
   import ehbi_pkg::*;

   ctrl_cmd_type cmd;
   logic         csr_we;

   // register writes never wait
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   // sequencing and handshakes
   ehbi_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_is_last (req_is_last),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd)
   );

   // hash, remainder and result storage
   ehbi_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_key_byte     (req_key_byte),
      .req_is_last      (req_is_last),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_bucket_index (rsp_bucket_index)
   );

endmodule

>>> test/elf_hash_bucket_index_tb.sv
// testbench for the elf hash bucket index block: bucket scoreboard, beat drivers and checks
`timescale 1ns / 1ps
module elf_hash_bucket_index_tb;
   import ehbi_pkg::*;

   typedef logic [HASH_W-1:0] word_type;
   typedef logic [BYTE_W-1:0] byte_type;
   typedef byte_type key_type[$];

   typedef struct {
      bit       fold;
      word_type buckets;
   } setting_type;

   // register indexes the block does not decode, used to show such writes are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LOW  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HIGH = '1;

   // settle time in cycles, given after the last bucket index has arrived
   localparam int RESULT_LATENCY = 40;
   // beat-free cycles before the run is declared hung
   localparam int WATCHDOG_LIMIT = 3000;
   // random key bytes spread over all register settings
   localparam int RANDOM_BYTES   = 600;

   // predicts the bucket index of every key and holds the ones not yet seen
   class bucket_scoreboard;
      bit       fold_case_on;
      word_type bucket_count;
      word_type partial_hash;
      word_type pending_buckets[$];
      int       bytes_seen;
      int       keys_seen;
      int       buckets_checked;
      int       mismatches;

      function new();
         fold_case_on = 1'b0;
         bucket_count = word_type'(256);
         partial_hash = '0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, word_type data);
         case (idx)
            CSR_IGNORE_CASE: fold_case_on = data[0];
            CSR_TABLE_SIZE:  bucket_count = data;
            default: ;
         endcase
      endfunction

      function void note_byte(byte_type key_byte, logic is_last);
         byte_type folded;
         word_type mixed;
         word_type top;
         folded = key_byte;
         if (fold_case_on && key_byte >= 8'h61 && key_byte <= 8'h7A) begin
            folded = key_byte - 8'h20;
         end
         mixed = (partial_hash << 4) + word_type'(folded);
         top   = mixed & 32'hF000_0000;
         if (top != '0) begin
            mixed = mixed ^ (top >> 24) ^ top;
         end
         bytes_seen++;
         if (!is_last) begin
            partial_hash = mixed;
         end else begin
            partial_hash = '0;
            keys_seen++;
            if (bucket_count == '0) begin
               pending_buckets.push_back(mixed);
            end else begin
               pending_buckets.push_back(mixed % bucket_count);
            end
         end
      endfunction

      function void check_bucket(word_type actual);
         word_type wanted;
         if (pending_buckets.size() == 0) begin
            $error("bucket_index: none expected, actual %0h", actual);
            mismatches++;
            return;
         end
         wanted = pending_buckets.pop_front();
         buckets_checked++;
         if (actual !== wanted) begin
            $error("bucket_index mismatch: expected %0h, actual %0h", wanted, actual);
            mismatches++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   byte_type               req_key_byte = '0;
   logic                   req_is_last = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   word_type               rsp_bucket_index;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   word_type               csr_data = '0;

   bucket_scoreboard buckets_sb = new();

   // idling switches, turned off for some settings to get back-to-back stretches
   bit sender_gaps     = 1'b1;
   bit receiver_stalls = 1'b1;
   int stall_left      = 0;
   int run_left        = 0;
   int idle_cycles     = 0;

   // bytes that sit just outside the letter ranges
   byte_type letter_edges[4] = '{8'h40, 8'h5B, 8'h60, 8'h7B};

   elf_hash_bucket_index i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_key_byte     (req_key_byte),
      .req_is_last      (req_is_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_bucket_index (rsp_bucket_index),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly no gap, often a short one, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // letters dominate so that case folding is exercised, the rest is any byte
   function automatic byte_type random_key_byte();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return byte_type'($urandom_range(8'h61, 8'h7A));
      if (roll < 60) return byte_type'($urandom_range(8'h41, 8'h5A));
      if (roll < 70) return letter_edges[$urandom_range(0, 3)];
      return byte_type'($urandom());
   endfunction

   // one key byte beat; valid stays high afterwards unless the next beat has a gap
   task automatic send_byte(byte_type key_byte, logic is_last);
      int gap;
      gap = sender_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_key_byte <= key_byte;
      req_is_last  <= is_last;
      do @(posedge clock); while (req_stall);
      buckets_sb.note_byte(key_byte, is_last);
   endtask

   task automatic send_key(key_type key);
      foreach (key[n]) send_byte(key[n], n == key.size() - 1);
   endtask

   // key lengths: mostly short, some medium, a few long enough to wrap the hash often
   task automatic send_random_key(output int len);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         len = $urandom_range(1, 8);
      end else if (roll < 95) begin
         len = $urandom_range(9, 20);
      end else begin
         len = $urandom_range(21, 48);
      end
      for (int n = 0; n < len; n++) send_byte(random_key_byte(), n == len - 1);
   endtask

   // drop valid, let every outstanding bucket index arrive, optionally let the block settle
   task automatic wait_drained(bit settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (buckets_sb.pending_buckets.size() != 0) @(posedge clock);
      if (settle) repeat (RESULT_LATENCY) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, word_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      buckets_sb.write_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // result side: check every accepted beat, then pick the stall for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         buckets_sb.check_bucket(rsp_bucket_index);
      end
      if (stall_left > 0) begin
         stall_left--;
      end else if (run_left > 0) begin
         run_left--;
      end else begin
         run_left   = $urandom_range(0, 10);
         stall_left = receiver_stalls ? pick_gap() : 0;
      end
      rsp_stall <= (stall_left > 0);
   end

   // hang detection: any beat on any channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no beat for %0d cycles", idle_cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      setting_type plan[$];
      key_type     key;
      int          phase_bytes;
      int          len;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed keys at the reset settings: case folding off, 256 buckets
      // all-zero and all-ones single bytes
      key = {8'h00};
      send_key(key);
      key = {8'hFF};
      send_key(key);
      // lower-case letters and their neighbours pass through unchanged
      key = {8'h61, 8'h7A, 8'h60, 8'h7B};
      send_key(key);
      // eight all-ones bytes push bits into the top nibble so the fold kicks in
      key = {};
      repeat (8) key.push_back(8'hFF);
      send_key(key);

      // zero table size returns the whole hash; case folding on; dropped indexes
      wait_drained(1'b1);
      write_csr(CSR_IGNORE_CASE, word_type'(1));
      write_csr(CSR_TABLE_SIZE, '0);
      write_csr(CSR_UNUSED_HIGH, '1);
      write_csr(CSR_UNUSED_LOW, '0);
      key = {8'h61, 8'h7A, 8'h60, 8'h7B, 8'h41, 8'h5A};
      send_key(key);
      key = {8'h40, 8'h5B};
      send_key(key);

      // settings for the random part, the extremes among them
      plan.push_back(setting_type'{1'b0, word_type'(1)});
      plan.push_back(setting_type'{1'b1, 32'hFFFF_FFFF});
      plan.push_back(setting_type'{1'b0, 32'hFFFF_FFFE});
      plan.push_back(setting_type'{1'b1, 32'h8000_0000});
      plan.push_back(setting_type'{1'b0, word_type'(97)});
      plan.push_back(setting_type'{1'b1, word_type'($urandom())});
      plan.push_back(setting_type'{1'b0, word_type'($urandom_range(2, 1000))});
      plan.push_back(setting_type'{1'b1, word_type'(3)});
      plan.push_back(setting_type'{1'b0, word_type'(0)});
      plan.push_back(setting_type'{1'b1, word_type'(2)});

      foreach (plan[i]) begin
         // registers only change once the block has finished every key
         wait_drained(1'b1);
         write_csr(CSR_IGNORE_CASE, word_type'(plan[i].fold));
         write_csr(CSR_TABLE_SIZE, plan[i].buckets);
         if (i == 5) write_csr(CSR_UNUSED_LOW, word_type'($urandom()));
         // one setting runs flat out, another with a receiver that never stalls
         sender_gaps     = (i != 3);
         receiver_stalls = (i != 3) && (i != 7);
         phase_bytes = 0;
         while (phase_bytes < RANDOM_BYTES / plan.size()) begin
            send_random_key(len);
            phase_bytes += len;
            // sender holds off after one key until its bucket index is back
            if (i == 4 && phase_bytes == len) wait_drained(1'b0);
         end
      end

      wait_drained(1'b1);

      $display("%0d key bytes in %0d keys, %0d bucket indexes compared",
               buckets_sb.bytes_seen, buckets_sb.keys_seen, buckets_sb.buckets_checked);
      $display("table sizes zero, one up to all ones, case folding on and off, gaps on both sides");
      if (buckets_sb.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
